[sv/dpf_pkg.sv]
`timescale 1ns / 1ps
package dpf_pkg;

   localparam int FRAC_BITS_DEFAULT = 16;
   localparam int DIST_W = 33;
   localparam int VEL_W = 33;
   localparam int CSR_INDEX_W = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_INV_SMOOTH  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CUTOFF      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CONS_COEFF  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DAMP_NORMAL = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_DAMP_TANG   = 3'd4;

   typedef struct packed {
      logic               command;
      logic signed [31:0] delta_x;
      logic signed [31:0] delta_y;
      logic signed [31:0] delta_z;
      logic        [30:0] interaction_radius;
      logic signed [31:0] indentation;
      logic signed [31:0] vel_t0;
      logic signed [31:0] vel_t1;
      logic signed [31:0] vel_normal;
   } req_payload_type;

   typedef struct packed {
      logic signed [31:0] conservative_force;
      logic signed [31:0] damping_t0;
      logic signed [31:0] damping_t1;
      logic signed [31:0] damping_n;
      logic               active;
   } rsp_payload_type;

   typedef struct packed {
      logic        [30:0] inverse_smoothing_length;
      logic        [30:0] cutoff_radius;
      logic signed [31:0] conservative_coeff;
      logic        [30:0] damping_normal;
      logic        [30:0] damping_tangential;
   } cfg_type;

   typedef struct packed {
      logic signed [VEL_W-1:0] vt0;
      logic signed [VEL_W-1:0] vt1;
      logic signed [VEL_W-1:0] vn;
   } vel_type;

   typedef struct packed {
      logic [DIST_W-1:0] r_len;
      vel_type           vel;
   } dist_type;

   localparam logic signed [79:0] SAT_MAX = 80'sd2147483647;
   localparam logic signed [79:0] SAT_MIN = -80'sd2147483648;

   function automatic logic signed [31:0] sat32(input logic signed [79:0] x);
      logic signed [31:0] r;
      if (x > SAT_MAX) r = 32'sh7fffffff;
      else if (x < SAT_MIN) r = 32'sh80000000;
      else r = x[31:0];
      return r;
   endfunction

endpackage

[sv/dpf_dist.sv]
`timescale 1ns / 1ps
module dpf_dist
   import dpf_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_ready,
   input  req_payload_type in_data,
   output logic            out_valid,
   input  logic            out_ready,
   output dist_type        out_data
);

   localparam int NSQ = 16;
   localparam int NS = NSQ + 2;

   typedef struct packed {
      logic [63:0]       n;
      logic [63:0]       res;
      logic              wall;
      logic [DIST_W-1:0] wr;
      vel_type           vel;
   } sq_stage_type;

   logic [NS-1:0] valid_ff;
   logic [NS:0]   ready;

   assign ready[NS] = out_ready;
   genvar k;
   generate
      for (k = 0; k < NS; k++) begin : g_rdy
         assign ready[k] = !valid_ff[k] || ready[k+1];
      end
   endgenerate
   assign in_ready = ready[0];
   assign out_valid = valid_ff[NS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (ready[0]) valid_ff[0] <= in_valid;
         for (int i = 1; i < NS; i++) begin
            if (ready[i]) valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   // stage 0: squares of the position difference, wall distance, scaled velocities
   logic [31:0]       ax, ay, az;
   logic [63:0]       sqx_in, sqy_in, sqz_in;
   logic signed [33:0] wd_raw;
   logic signed [33:0] wd_clip;
   logic [DIST_W-1:0] wr_in;
   vel_type           vel_in;

   assign ax = in_data.delta_x[31] ? 32'(-in_data.delta_x) : in_data.delta_x;
   assign ay = in_data.delta_y[31] ? 32'(-in_data.delta_y) : in_data.delta_y;
   assign az = in_data.delta_z[31] ? 32'(-in_data.delta_z) : in_data.delta_z;
   assign sqx_in = ax * ax;
   assign sqy_in = ay * ay;
   assign sqz_in = az * az;

   assign wd_raw = $signed({3'b000, in_data.interaction_radius}) - 34'(in_data.indentation);
   assign wd_clip = (wd_raw < 34'sd1) ? 34'sd1 : wd_raw;
   assign wr_in = {wd_clip[31:0], 1'b0};

   always_comb begin
      if (in_data.command) begin
         vel_in.vt0 = {in_data.vel_t0, 1'b0};
         vel_in.vt1 = {in_data.vel_t1, 1'b0};
         vel_in.vn  = {in_data.vel_normal, 1'b0};
      end else begin
         vel_in.vt0 = VEL_W'(in_data.vel_t0);
         vel_in.vt1 = VEL_W'(in_data.vel_t1);
         vel_in.vn  = VEL_W'(in_data.vel_normal);
      end
   end

   logic [63:0]       sqx_ff, sqy_ff, sqz_ff;
   logic              wall0_ff;
   logic [DIST_W-1:0] wr0_ff;
   vel_type           vel0_ff;

   always_ff @(posedge clock) begin
      if (ready[0]) begin
         sqx_ff   <= sqx_in;
         sqy_ff   <= sqy_in;
         sqz_ff   <= sqz_in;
         wall0_ff <= in_data.command;
         wr0_ff   <= wr_in;
         vel0_ff  <= vel_in;
      end
   end

   sq_stage_type st_ff [1:NS-1];

   // stage 1: sum of squares
   always_ff @(posedge clock) begin
      if (ready[1]) begin
         st_ff[1].n    <= sqx_ff + sqy_ff + sqz_ff;
         st_ff[1].res  <= '0;
         st_ff[1].wall <= wall0_ff;
         st_ff[1].wr   <= wr0_ff;
         st_ff[1].vel  <= vel0_ff;
      end
   end

   // square root, two result bits per stage
   genvar j;
   generate
      for (j = 0; j < NSQ; j++) begin : g_sq
         localparam logic [63:0] BIT_HI = 64'd1 << (2 * (31 - 2 * j));
         localparam logic [63:0] BIT_LO = 64'd1 << (2 * (30 - 2 * j));
         logic [63:0]  n_mid, res_mid;
         sq_stage_type nxt;

         always_comb begin
            nxt = st_ff[j+1];
            if (st_ff[j+1].n >= st_ff[j+1].res + BIT_HI) begin
               n_mid = st_ff[j+1].n - (st_ff[j+1].res + BIT_HI);
               res_mid = (st_ff[j+1].res >> 1) + BIT_HI;
            end else begin
               n_mid = st_ff[j+1].n;
               res_mid = st_ff[j+1].res >> 1;
            end
            if (n_mid >= res_mid + BIT_LO) begin
               nxt.n = n_mid - (res_mid + BIT_LO);
               nxt.res = (res_mid >> 1) + BIT_LO;
            end else begin
               nxt.n = n_mid;
               nxt.res = res_mid >> 1;
            end
         end

         always_ff @(posedge clock) begin
            if (ready[j+2]) st_ff[j+2] <= nxt;
         end
      end
   endgenerate

   assign out_data.r_len = st_ff[NS-1].wall ? st_ff[NS-1].wr : st_ff[NS-1].res[DIST_W-1:0];
   assign out_data.vel = st_ff[NS-1].vel;

endmodule

[sv/dpf_kern.sv]
`timescale 1ns / 1ps
module dpf_kern
   import dpf_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cfg_type              cfg,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  dist_type             in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [FRAC_BITS:0]   out_w,
   output logic [FRAC_BITS:0]   out_wd,
   output logic                 out_active,
   output vel_type              out_vel
);

   localparam int NS = 5;
   localparam int TW = FRAC_BITS + 1;
   localparam int QW = 62 - FRAC_BITS;
   localparam logic [QW-1:0] ONE_Q = QW'(1) << FRAC_BITS;
   localparam logic [QW-1:0] TWO_Q = QW'(2) << FRAC_BITS;
   localparam logic [TW-1:0] ONE_T = TW'(1) << FRAC_BITS;

   logic [NS-1:0] valid_ff;
   logic [NS:0]   ready;

   assign ready[NS] = out_ready;
   genvar k;
   generate
      for (k = 0; k < NS; k++) begin : g_rdy
         assign ready[k] = !valid_ff[k] || ready[k+1];
      end
   endgenerate
   assign in_ready = ready[0];
   assign out_valid = valid_ff[NS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (ready[0]) valid_ff[0] <= in_valid;
         for (int i = 1; i < NS; i++) begin
            if (ready[i]) valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   logic    act0_ff, act1_ff, act2_ff, act3_ff, act4_ff;
   vel_type vel0_ff, vel1_ff, vel2_ff, vel3_ff, vel4_ff;

   // stage 0: range check and q = r / h
   logic [61:0] qprod;
   logic        act_in;
   logic [QW-1:0] q_ff;

   assign qprod = in_data.r_len[30:0] * cfg.inverse_smoothing_length;
   assign act_in = (in_data.r_len != '0) && (in_data.r_len < DIST_W'(cfg.cutoff_radius));

   always_ff @(posedge clock) begin
      if (ready[0]) begin
         q_ff    <= qprod[61:FRAC_BITS];
         act0_ff <= act_in;
         vel0_ff <= in_data.vel;
      end
   end

   // stage 1: branch select and first square
   logic          inner_in, outer_in;
   logic [QW-1:0] s_full;
   logic [TW-1:0] t_in;
   logic [2*TW-1:0] tt;
   logic [TW-1:0] t_ff, t2_ff;
   logic          inner1_ff, outer1_ff;

   assign inner_in = q_ff < ONE_Q;
   assign outer_in = !inner_in && (q_ff < TWO_Q);
   assign s_full = TWO_Q - q_ff;
   assign t_in = inner_in ? q_ff[TW-1:0] : s_full[TW-1:0];
   assign tt = t_in * t_in;

   always_ff @(posedge clock) begin
      if (ready[1]) begin
         t_ff      <= t_in;
         t2_ff     <= tt[FRAC_BITS +: TW];
         inner1_ff <= inner_in;
         outer1_ff <= outer_in;
         act1_ff   <= act0_ff;
         vel1_ff   <= vel0_ff;
      end
   end

   // stage 2: cube
   logic [2*TW-1:0] ttt;
   logic [TW-1:0]   t2b_ff, t3_ff;
   logic            inner2_ff, outer2_ff;

   assign ttt = t2_ff * t_ff;

   always_ff @(posedge clock) begin
      if (ready[2]) begin
         t2b_ff    <= t2_ff;
         t3_ff     <= ttt[FRAC_BITS +: TW];
         inner2_ff <= inner1_ff;
         outer2_ff <= outer1_ff;
         act2_ff   <= act1_ff;
         vel2_ff   <= vel1_ff;
      end
   end

   // stage 3: kernel weight
   logic [TW+1:0]        t2x3, t3x3;
   logic signed [TW+2:0] wi;
   logic [TW-1:0]        w_in;
   logic [TW-1:0]        w_ff;

   assign t2x3 = (TW+2)'({t2b_ff, 1'b0}) + (TW+2)'(t2b_ff);
   assign t3x3 = (TW+2)'({t3_ff, 1'b0}) + (TW+2)'(t3_ff);
   assign wi = $signed((TW+3)'(ONE_T)) - $signed((TW+3)'(t2x3[TW+1:1]))
             + $signed((TW+3)'(t3x3[TW+1:2]));

   always_comb begin
      if (inner2_ff) w_in = wi[TW+2] ? '0 : wi[TW-1:0];
      else if (outer2_ff) w_in = t3_ff >> 2;
      else w_in = '0;
   end

   always_ff @(posedge clock) begin
      if (ready[3]) begin
         w_ff    <= w_in;
         act3_ff <= act2_ff;
         vel3_ff <= vel2_ff;
      end
   end

   // stage 4: squared weight for damping
   logic [2*TW-1:0] ww;
   logic [TW-1:0]   w4_ff, wd_ff;

   assign ww = w_ff * w_ff;

   always_ff @(posedge clock) begin
      if (ready[4]) begin
         w4_ff   <= w_ff;
         wd_ff   <= ww[FRAC_BITS +: TW];
         act4_ff <= act3_ff;
         vel4_ff <= vel3_ff;
      end
   end

   assign out_w = w4_ff;
   assign out_wd = wd_ff;
   assign out_active = act4_ff;
   assign out_vel = vel4_ff;

endmodule

[sv/dpf_force.sv]
`timescale 1ns / 1ps
module dpf_force
   import dpf_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic [FRAC_BITS:0] in_w,
   input  logic [FRAC_BITS:0] in_wd,
   input  logic               in_active,
   input  vel_type            in_vel,
   output logic               out_valid,
   input  logic               out_ready,
   output rsp_payload_type    out_data
);

   localparam int NS = 3;
   localparam int TW = FRAC_BITS + 1;
   localparam int CPW = 33 + TW;

   logic [NS-1:0] valid_ff;
   logic [NS:0]   ready;

   assign ready[NS] = out_ready;
   genvar k;
   generate
      for (k = 0; k < NS; k++) begin : g_rdy
         assign ready[k] = !valid_ff[k] || ready[k+1];
      end
   endgenerate
   assign in_ready = ready[0];
   assign out_valid = valid_ff[NS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (ready[0]) valid_ff[0] <= in_valid;
         for (int i = 1; i < NS; i++) begin
            if (ready[i]) valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   // stage 0: damping gains and conservative product
   logic [30+TW:0]        pt, pn;
   logic signed [CPW-1:0] cprod;
   logic [30:0]           gt_ff, gn_ff;
   logic signed [CPW-1:0] cprod_ff;
   logic                  act0_ff, act1_ff;
   vel_type               vel0_ff;

   assign pt = cfg.damping_tangential * in_wd;
   assign pn = cfg.damping_normal * in_wd;
   assign cprod = cfg.conservative_coeff * $signed({1'b0, in_w});

   always_ff @(posedge clock) begin
      if (ready[0]) begin
         gt_ff    <= pt[FRAC_BITS +: 31];
         gn_ff    <= pn[FRAC_BITS +: 31];
         cprod_ff <= cprod;
         act0_ff  <= in_active;
         vel0_ff  <= in_vel;
      end
   end

   // stage 1: gain times negated velocity
   logic signed [33:0] nv0, nv1, nvn;
   logic signed [65:0] d0_in, d1_in, dn_in;
   logic signed [65:0] d0_ff, d1_ff, dn_ff;
   logic signed [31:0] cons_ff;

   assign nv0 = -34'(vel0_ff.vt0);
   assign nv1 = -34'(vel0_ff.vt1);
   assign nvn = -34'(vel0_ff.vn);
   assign d0_in = $signed({1'b0, gt_ff}) * nv0;
   assign d1_in = $signed({1'b0, gt_ff}) * nv1;
   assign dn_in = $signed({1'b0, gn_ff}) * nvn;

   always_ff @(posedge clock) begin
      if (ready[1]) begin
         d0_ff   <= d0_in;
         d1_ff   <= d1_in;
         dn_ff   <= dn_in;
         cons_ff <= sat32(80'(cprod_ff >>> FRAC_BITS));
         act1_ff <= act0_ff;
      end
   end

   // stage 2: scale, saturate, zero out-of-reach items
   rsp_payload_type res_in;
   rsp_payload_type res_ff;

   always_comb begin
      res_in = '0;
      if (act1_ff) begin
         res_in.conservative_force = cons_ff;
         res_in.damping_t0 = sat32(80'(d0_ff >>> FRAC_BITS));
         res_in.damping_t1 = sat32(80'(d1_ff >>> FRAC_BITS));
         res_in.damping_n  = sat32(80'(dn_ff >>> FRAC_BITS));
         res_in.active = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ready[2]) res_ff <= res_in;
   end

   assign out_data = res_ff;

endmodule

[sv/dpd_pair_force_unit.sv]
`timescale 1ns / 1ps
// pairwise force unit: one pair in, one result out, Q16.16 fixed point by default
// req channel: req_valid / req_stall / req_payload; a transfer happens when
//   req_valid is high and req_stall is low
// rsp channel: rsp_valid / rsp_stall / rsp_payload, same rule, rsp_stall from the sink
// csr channel: csr_valid / csr_ready / csr_index / csr_data; csr_ready is always high,
//   unknown indexes are dropped; write only while no pair is in flight
// from req transfer to rsp_valid a pair passes the distance stages (squares, sum,
//   16 square root stages at two bits each), the kernel weight stages, the force
//   products and saturation stages, and the output register
// throughput is one pair per cycle while the result is not stalled; each stage holds
//   its item while the stage after it is full, so bubbles close up and req_stall rises
//   only once the whole pipe is full behind a stalled result
// reset clears all valid bits and loads the register defaults: 1/h = 1.0,
//   cutoff = 2.0, all coefficients 0
module dpd_pair_force_unit
   import dpf_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_payload_type        req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_payload_type        rsp_payload,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]            csr_data
);

   localparam logic [30:0] ISL_RESET = 31'(1) << FRAC_BITS;
   localparam logic [30:0] CUTOFF_RESET = 31'(2) << FRAC_BITS;

   cfg_type cfg_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.inverse_smoothing_length <= ISL_RESET;
         cfg_ff.cutoff_radius <= CUTOFF_RESET;
         cfg_ff.conservative_coeff <= '0;
         cfg_ff.damping_normal <= '0;
         cfg_ff.damping_tangential <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_INV_SMOOTH:  cfg_ff.inverse_smoothing_length <= csr_data[30:0];
            CSR_CUTOFF:      cfg_ff.cutoff_radius <= csr_data[30:0];
            CSR_CONS_COEFF:  cfg_ff.conservative_coeff <= csr_data;
            CSR_DAMP_NORMAL: cfg_ff.damping_normal <= csr_data[30:0];
            CSR_DAMP_TANG:   cfg_ff.damping_tangential <= csr_data[30:0];
            default: ;
         endcase
      end
   end

   logic     d_in_ready, d_valid, d_ready;
   dist_type d_data;

   dpf_dist u_dist (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (d_in_ready),
      .in_data   (req_payload),
      .out_valid (d_valid),
      .out_ready (d_ready),
      .out_data  (d_data)
   );

   assign req_stall = !d_in_ready;

   logic               k_valid, k_ready, k_active;
   logic [FRAC_BITS:0] k_w, k_wd;
   vel_type            k_vel;

   dpf_kern #(.FRAC_BITS(FRAC_BITS)) u_kern (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .in_valid   (d_valid),
      .in_ready   (d_ready),
      .in_data    (d_data),
      .out_valid  (k_valid),
      .out_ready  (k_ready),
      .out_w      (k_w),
      .out_wd     (k_wd),
      .out_active (k_active),
      .out_vel    (k_vel)
   );

   logic            f_valid, f_ready;
   rsp_payload_type f_data;

   dpf_force #(.FRAC_BITS(FRAC_BITS)) u_force (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (k_valid),
      .in_ready  (k_ready),
      .in_w      (k_w),
      .in_wd     (k_wd),
      .in_active (k_active),
      .in_vel    (k_vel),
      .out_valid (f_valid),
      .out_ready (f_ready),
      .out_data  (f_data)
   );

   // output register
   logic            rsp_valid_ff;
   rsp_payload_type rsp_payload_ff;

   assign f_ready = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (f_ready) begin
         rsp_valid_ff <= f_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (f_ready && f_valid) rsp_payload_ff <= f_data;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   a_inactive_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_payload_ff.active |->
         rsp_payload_ff.conservative_force == '0 && rsp_payload_ff.damping_t0 == '0 &&
         rsp_payload_ff.damping_t1 == '0 && rsp_payload_ff.damping_n == '0)
      else $error("inactive result carries a nonzero force");

   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid_ff && rsp_stall)
      else $error("input stalled without a stalled result");

   a_hold_in_pipe: assert property (@(posedge clock) disable iff (reset)
      f_valid && !f_ready |=> f_valid)
      else $error("finished item lost while output register was full");

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
module tb;
   import dpf_pkg::*;

   localparam int FB = 16;
   localparam int LATENCY = 27;
   localparam longint CYCLE_LIMIT = 400000;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   req_payload_type req_payload;
   logic rsp_valid;
   logic rsp_stall;
   rsp_payload_type rsp_payload;
   logic csr_valid;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [31:0] csr_data;

   dpd_pair_force_unit DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // mirror of the register file
   logic [30:0] inv_h;
   logic [30:0] cutoff;
   logic signed [31:0] coeff_a;
   logic [30:0] gamma_n;
   logic [30:0] gamma_t;

   rsp_payload_type expected_forces[$];
   int errors = 0;
   longint cycles = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   logic hold_rsp = 1'b0;

   function automatic logic [63:0] int_sqrt(input logic [63:0] n);
      logic [63:0] res;
      logic [63:0] b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= res + b) begin
            n = n - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic logic signed [31:0] clip32(input logic signed [127:0] x);
      if (x > 128'sd2147483647) return 32'sh7fffffff;
      if (x < -128'sd2147483648) return 32'sh80000000;
      return x[31:0];
   endfunction

   // arithmetic shift of a signed value floors toward minus infinity
   function automatic logic signed [31:0] damping_force(input logic [30:0] gamma,
         input logic [63:0] wd, input logic signed [63:0] v);
      logic signed [127:0] g;
      logic signed [127:0] p;
      g = $signed({65'd0, 63'((64'(gamma) * wd) >> FB)});
      p = -(g * 128'(v));
      return clip32(p >>> FB);
   endfunction

   function automatic rsp_payload_type pair_force(input req_payload_type it);
      rsp_payload_type o;
      logic signed [63:0] vt0, vt1, vn, dd, dx, dy, dz;
      logic [63:0] r, q, w, wd, s, s2, s3, q2, q3;
      logic signed [63:0] wi;
      logic signed [127:0] cons;
      o = '0;
      vt0 = 64'(it.vel_t0);
      vt1 = 64'(it.vel_t1);
      vn = 64'(it.vel_normal);
      if (it.command) begin
         dd = $signed({33'd0, it.interaction_radius}) - 64'(it.indentation);
         if (dd < 1) dd = 1;
         r = 64'(dd) * 2;
         vt0 = vt0 * 2;
         vt1 = vt1 * 2;
         vn = vn * 2;
      end else begin
         dx = 64'(it.delta_x);
         dy = 64'(it.delta_y);
         dz = 64'(it.delta_z);
         r = int_sqrt(64'(dx * dx) + 64'(dy * dy) + 64'(dz * dz));
      end
      if (r == 0 || r >= 64'(cutoff)) return o;
      q = (r * 64'(inv_h)) >> FB;
      if (q < (64'd1 << FB)) begin
         q2 = (q * q) >> FB;
         q3 = (q2 * q) >> FB;
         wi = $signed(64'd1 << FB) - $signed((3 * q2) >> 1) + $signed((3 * q3) >> 2);
         w = (wi < 0) ? 64'd0 : 64'(wi);
      end else if (q < (64'd2 << FB)) begin
         s = (64'd2 << FB) - q;
         s2 = (s * s) >> FB;
         s3 = (s2 * s) >> FB;
         w = s3 >> 2;
      end else begin
         w = 0;
      end
      wd = (w * w) >> FB;
      cons = 128'(coeff_a) * $signed({64'd0, w});
      o.conservative_force = clip32(cons >>> FB);
      o.damping_t0 = damping_force(gamma_t, wd, vt0);
      o.damping_t1 = damping_force(gamma_t, wd, vt1);
      o.damping_n = damping_force(gamma_n, wd, vn);
      o.active = 1'b1;
      return o;
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout at %0t", $time);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // receiver stall
   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b1;
      else rsp_stall <= hold_rsp || ($urandom_range(99) < recv_idle_pct);
   end

   // result checker
   always @(posedge clock) begin
      rsp_payload_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_forces.size() == 0) begin
            $display("%0t unexpected result: expected none, actual %h", $time, rsp_payload);
            errors++;
         end else begin
            e = expected_forces.pop_front();
            if (rsp_payload.conservative_force !== e.conservative_force) begin
               $display("%0t conservative_force: expected %0d, actual %0d", $time,
                        e.conservative_force, rsp_payload.conservative_force);
               errors++;
            end
            if (rsp_payload.damping_t0 !== e.damping_t0) begin
               $display("%0t damping_t0: expected %0d, actual %0d", $time,
                        e.damping_t0, rsp_payload.damping_t0);
               errors++;
            end
            if (rsp_payload.damping_t1 !== e.damping_t1) begin
               $display("%0t damping_t1: expected %0d, actual %0d", $time,
                        e.damping_t1, rsp_payload.damping_t1);
               errors++;
            end
            if (rsp_payload.damping_n !== e.damping_n) begin
               $display("%0t damping_n: expected %0d, actual %0d", $time,
                        e.damping_n, rsp_payload.damping_n);
               errors++;
            end
            if (rsp_payload.active !== e.active) begin
               $display("%0t active: expected %0d, actual %0d", $time,
                        e.active, rsp_payload.active);
               errors++;
            end
         end
      end
   end

   // valid stays up after a transfer so the next pair can follow at once
   task automatic send_pair(input req_payload_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_forces.push_back(pair_force(it));
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (expected_forces.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_INV_SMOOTH:  inv_h = val[30:0];
         CSR_CUTOFF:      cutoff = val[30:0];
         CSR_CONS_COEFF:  coeff_a = val;
         CSR_DAMP_NORMAL: gamma_n = val[30:0];
         CSR_DAMP_TANG:   gamma_t = val[30:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_regs(input logic [31:0] ih, input logic [31:0] rc,
         input logic [31:0] a, input logic [31:0] gn, input logic [31:0] gt);
      write_reg(CSR_INV_SMOOTH, ih);
      write_reg(CSR_CUTOFF, rc);
      write_reg(CSR_CONS_COEFF, a);
      write_reg(CSR_DAMP_NORMAL, gn);
      write_reg(CSR_DAMP_TANG, gt);
   endtask

   function automatic logic [31:0] rand_word;
      case ($urandom_range(5))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return $urandom_range(0, 32'h3ffff) - 32'h1ffff;
         default: return $urandom;
      endcase
   endfunction

   // many distances near the kernel support so weights are nonzero
   function automatic req_payload_type rand_pair(input int scale);
      req_payload_type it;
      it.command = $urandom_range(1);
      it.delta_x = ($urandom_range(1) ? rand_word() : $signed($urandom_range(0, 2 * scale)) - scale);
      it.delta_y = ($urandom_range(3) == 0 ? rand_word() : $signed($urandom_range(0, 2 * scale)) - scale);
      it.delta_z = ($urandom_range(3) == 0 ? rand_word() : $signed($urandom_range(0, 2 * scale)) - scale);
      it.interaction_radius = ($urandom_range(3) == 0) ? 31'($urandom) : 31'($urandom_range(0, scale));
      it.indentation = ($urandom_range(3) == 0) ? rand_word()
                       : $signed($urandom_range(0, scale)) - scale / 4;
      it.vel_t0 = rand_word();
      it.vel_t1 = rand_word();
      it.vel_normal = rand_word();
      return it;
   endfunction

   task automatic test_directed;
      req_payload_type it;
      set_regs(32'h10000, 32'h20000, 32'h30000, 32'h8000, 32'h18000);
      it = '0;
      send_pair(it);                       // zero distance
      it.delta_x = 32'h8000; send_pair(it);
      it.delta_x = -32'sh18000; it.vel_t0 = 32'h7fffffff; it.vel_t1 = 32'h80000000;
      it.vel_normal = -32'sd1; send_pair(it);
      it.delta_x = 32'h20000; send_pair(it);  // exactly at cutoff
      it.delta_x = 32'h7fffffff; it.delta_y = 32'h80000000; it.delta_z = 32'h7fffffff;
      send_pair(it);
      it = '0; it.command = 1'b1; it.interaction_radius = 31'h8000; it.indentation = 0;
      it.vel_t0 = 32'h80000000; it.vel_t1 = 32'h7fffffff; it.vel_normal = 32'h12345;
      send_pair(it);
      it.indentation = 32'h7fffffff; send_pair(it);  // clamps to one lsb
      it.interaction_radius = 31'h7fffffff; it.indentation = 32'h80000000; send_pair(it);
      it.interaction_radius = 31'h4000; it.indentation = 32'h1000; send_pair(it);
      drain();
      // big coefficients saturate
      set_regs(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff);
      it = '0; it.delta_x = 1; it.vel_t0 = 32'h7fffffff; it.vel_t1 = 32'h80000000;
      it.vel_normal = 32'h80000000; send_pair(it);
      it.command = 1'b1; it.interaction_radius = 31'd0; it.indentation = 32'h7fffffff;
      send_pair(it);
      drain();
      // zero smoothing gives full weight, then zero cutoff
      set_regs(32'h0, 32'h7fffffff, 32'h7fffffff, 32'h10000, 32'h10000);
      it = '0; it.delta_z = 32'h40000; it.vel_t0 = 32'h10000; it.vel_normal = -32'sh10000;
      send_pair(it);
      drain();
      write_reg(3'd7, 32'hffffffff);       // unknown index ignored
      write_reg(3'd5, 32'h0);
      send_pair(it);
      drain();
      set_regs(32'h10000, 32'h0, 32'h10000, 32'h10000, 32'h10000);
      send_pair(it);
      drain();
   endtask

   task automatic test_random(input int count);
      int scale;
      for (int n = 0; n < count; n++) begin
         scale = ($urandom_range(3) == 0) ? 32'h40000 : ((cutoff > 4) ? int'(cutoff) : 32'h20000);
         send_pair(rand_pair(scale));
      end
      drain();
   endtask

   task automatic test_backpressure;
      hold_rsp = 1'b1;
      send_idle_pct = 0;
      fork
         begin
            for (int n = 0; n < 60; n++) send_pair(rand_pair(32'h20000));
         end
         begin
            repeat (150) @(posedge clock);
            hold_rsp = 1'b0;
         end
      join
      drain();
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      inv_h = 31'h10000;
      cutoff = 31'h20000;
      coeff_a = 0;
      gamma_n = 0;
      gamma_t = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_random(10);                     // reset register values
      test_directed();
      send_idle_pct = 20; recv_idle_pct = 72;
      set_regs(32'h10000, 32'h20000, 32'h40000, 32'h20000, 32'h10000);
      test_random(270);
      send_idle_pct = 72; recv_idle_pct = 20;
      set_regs(32'h8000, 32'h40000, -32'sh50000, 32'h7fffffff, 32'h1000);
      test_random(270);
      send_idle_pct = 0; recv_idle_pct = 0;
      set_regs(32'h30000, 32'h10000, 32'h7fffffff, 32'h100, 32'h7fffffff);
      test_random(270);
      test_backpressure();
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

[files.f]
sv/dpf_pkg.sv
sv/dpf_dist.sv
sv/dpf_kern.sv
sv/dpf_force.sv
sv/dpd_pair_force_unit.sv
tb/tb.sv
